// ===== rtl/hkrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hkrt_pkg;

    // operation codes carried in the func field
    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_REQUEST = 2'd1,
        FUNC_POP_DUE = 2'd2,
        FUNC_POP_ANY = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] key_code;
        logic [31:0] now_ms;
        logic [31:0] hold_ms;
        logic        consumes_flag;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] released_code;
        logic        released_consumes;
        logic        table_empty;
        logic        release_waiting;
    } out_item_t;

    // payload kept in the slot memory
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] deadline;
        logic        consumes;
    } slot_word_t;

    // write command from the sequencer to the slot store
    typedef struct packed {
        logic wr_word;
        logic set_used;
        logic clr_used;
        logic set_asked;
        logic clr_asked;
    } slot_cmd_t;

    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2,
        ST_DONE  = 2'd3
    } ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/held_key_release_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                         | accepted when
// --------+---------------------------------+---------------------------
// input   | in_valid, in_ready, in_item     | in_valid && in_ready
// output  | out_valid, out_ready, out_item  | out_valid && out_ready
//
// one item at a time: a full scan reads every slot, then writes and returns the
// result; a press merge, request or pop that hits a slot ends the scan early
// the slot memory is read one slot a cycle, that single read port sets the rate
// rst_n clears the used and release bits, so every slot starts empty
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not hold off the next item, only the next result

module held_key_release_table_unit #(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hkrt_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hkrt_pkg::out_item_t       out_item
);

    // index width, at least one bit so a single-slot table still elaborates
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // sequencer to slot store
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    hkrt_pkg::slot_word_t   rd_word;
    logic                   rd_used;
    logic                   rd_asked;
    logic [IDX_W-1:0]       wr_idx;
    hkrt_pkg::slot_cmd_t    cmd;
    hkrt_pkg::slot_word_t   wr_word;
    logic                   used_any;
    logic                   asked_any;

    // shared add/subtract unit
    hkrt_pkg::alu_op_t      alu_op;
    logic [31:0]            alu_a;
    logic [31:0]            alu_b;
    logic [31:0]            alu_sum;
    logic                   alu_key_eq;

    // result hand-off into the output register
    logic                   res_valid;
    hkrt_pkg::out_item_t    res_item;
    logic                   res_taken;
    logic                   out_valid_reg, out_valid_next;
    hkrt_pkg::out_item_t    out_item_reg;

    // code of the item being worked on, captured at accept
    logic [15:0]            u_ctrl_key_code;
    logic [15:0]            key_code_reg;

    hkrt_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .res_valid  (res_valid),
        .res_item   (res_item),
        .res_taken  (res_taken),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_word    (rd_word),
        .rd_used    (rd_used),
        .rd_asked   (rd_asked),
        .wr_idx     (wr_idx),
        .cmd        (cmd),
        .wr_word    (wr_word),
        .used_any   (used_any),
        .asked_any  (asked_any),
        .alu_op     (alu_op),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_sum    (alu_sum),
        .alu_key_eq (alu_key_eq)
    );

    hkrt_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_slot_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .rd_word   (rd_word),
        .rd_used   (rd_used),
        .rd_asked  (rd_asked),
        .wr_idx    (wr_idx),
        .cmd       (cmd),
        .wr_word   (wr_word),
        .used_any  (used_any),
        .asked_any (asked_any)
    );

    // key compare works on the word read last cycle against the item code
    hkrt_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .key_a  (rd_word.key),
        .key_b  (u_ctrl_key_code),
        .sum    (alu_sum),
        .key_eq (alu_key_eq)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_code_reg <= in_item.key_code;
        end
    end

    assign u_ctrl_key_code = key_code_reg;

    // output register: a finished result may wait here while the next item runs
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_item_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/hkrt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkrt_alu (
    input  wire hkrt_pkg::alu_op_t op,
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    input  wire logic [15:0]       key_a,
    input  wire logic [15:0]       key_b,
    output logic [31:0]            sum,
    output logic                   key_eq
);

    // one adder/subtractor, shared by the due check and the deadline
    always_comb
    begin
        case (op)
            hkrt_pkg::ALU_ADD: sum = a + b;
            hkrt_pkg::ALU_SUB: sum = a - b;
            default:           sum = a - b;
        endcase
    end

    assign key_eq = (key_a == key_b);

endmodule

`default_nettype wire

// ===== rtl/hkrt_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkrt_slot_mem #(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_en,
    input  wire logic [IDX_W-1:0]       rd_idx,
    output hkrt_pkg::slot_word_t        rd_word,
    output logic                        rd_used,
    output logic                        rd_asked,
    input  wire logic [IDX_W-1:0]       wr_idx,
    input  wire hkrt_pkg::slot_cmd_t    cmd,
    input  wire hkrt_pkg::slot_word_t   wr_word,
    output logic                        used_any,
    output logic                        asked_any
);

    hkrt_pkg::slot_word_t   mem [SLOT_COUNT];
    hkrt_pkg::slot_word_t   rd_word_reg;
    logic                   rd_used_reg;
    logic                   rd_asked_reg;
    logic [SLOT_COUNT-1:0]  used_reg;
    logic [SLOT_COUNT-1:0]  used_next;
    logic [SLOT_COUNT-1:0]  asked_reg;
    logic [SLOT_COUNT-1:0]  asked_next;

    // payload store, contents only meaningful where the used bit is set
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx];
        end
        if (cmd.wr_word)
        begin
            mem[wr_idx] <= wr_word;
        end
    end

    always_comb
    begin
        used_next  = used_reg;
        asked_next = asked_reg;
        if (cmd.set_used)
        begin
            used_next[wr_idx] = 1'b1;
        end
        if (cmd.clr_used)
        begin
            used_next[wr_idx] = 1'b0;
        end
        if (cmd.set_asked)
        begin
            asked_next[wr_idx] = 1'b1;
        end
        if (cmd.clr_asked)
        begin
            asked_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            asked_reg    <= '0;
            rd_used_reg  <= 1'b0;
            rd_asked_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            asked_reg <= asked_next;
            if (rd_en)
            begin
                rd_used_reg  <= used_reg[rd_idx];
                rd_asked_reg <= asked_reg[rd_idx];
            end
        end
    end

    assign rd_word   = rd_word_reg;
    assign rd_used   = rd_used_reg;
    assign rd_asked  = rd_asked_reg;
    assign used_any  = |used_reg;
    assign asked_any = |(used_reg & asked_reg);

endmodule

`default_nettype wire

// ===== rtl/hkrt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkrt_ctrl #(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire hkrt_pkg::in_item_t     in_item,
    output logic                        res_valid,
    output hkrt_pkg::out_item_t         res_item,
    input  wire logic                   res_taken,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_idx,
    input  wire hkrt_pkg::slot_word_t   rd_word,
    input  wire logic                   rd_used,
    input  wire logic                   rd_asked,
    output logic [IDX_W-1:0]            wr_idx,
    output hkrt_pkg::slot_cmd_t         cmd,
    output hkrt_pkg::slot_word_t        wr_word,
    input  wire logic                   used_any,
    input  wire logic                   asked_any,
    output hkrt_pkg::alu_op_t           alu_op,
    output logic [31:0]                 alu_a,
    output logic [31:0]                 alu_b,
    input  wire logic [31:0]            alu_sum,
    input  wire logic                   alu_key_eq
);

    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    hkrt_pkg::ctrl_state_t  state_reg, state_next;
    hkrt_pkg::in_item_t     item_reg, item_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    hkrt_pkg::slot_word_t   hit_word_reg, hit_word_next;
    logic                   free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   ok_reg, ok_next;
    logic                   rel_reg, rel_next;
    logic                   slot_hit;
    logic                   code_zero;

    // per-slot decision on the word read last cycle
    always_comb
    begin
        case (item_reg.func)
            hkrt_pkg::FUNC_PRESS:   slot_hit = rd_used && alu_key_eq;
            hkrt_pkg::FUNC_REQUEST: slot_hit = rd_used && alu_key_eq;
            hkrt_pkg::FUNC_POP_DUE: slot_hit = rd_used && rd_asked && !alu_sum[31];
            hkrt_pkg::FUNC_POP_ANY: slot_hit = rd_used;
            default:                slot_hit = 1'b0;
        endcase
    end

    assign code_zero = (item_reg.key_code == 16'd0);

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_word_next = hit_word_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        ok_next       = ok_reg;
        rel_next      = rel_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = cnt_reg[IDX_W-1:0];
        wr_idx        = hit_idx_reg;
        cmd           = '0;
        wr_word       = hit_word_reg;
        alu_op        = hkrt_pkg::ALU_SUB;
        alu_a         = item_reg.now_ms;
        alu_b         = rd_word.deadline;

        res_item.ok                = ok_reg;
        res_item.released_code     = rel_reg ? hit_word_reg.key : 16'd0;
        res_item.released_consumes = rel_reg ? hit_word_reg.consumes : 1'b0;
        res_item.table_empty       = !used_any;
        res_item.release_waiting   = asked_any;

        case (state_reg)
            hkrt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next     = in_item;
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = hkrt_pkg::ST_SCAN;
                end
            end
            hkrt_pkg::ST_SCAN:
            begin
                if (cnt_reg < CNT_END)
                begin
                    rd_en        = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (slot_hit)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_word_next = rd_word;
                        cmp_vld_next  = 1'b0;
                        state_next    = hkrt_pkg::ST_WRITE;
                    end
                    else
                    begin
                        if (!rd_used && !free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            cmp_vld_next = 1'b0;
                            state_next   = hkrt_pkg::ST_WRITE;
                        end
                    end
                end
            end
            hkrt_pkg::ST_WRITE:
            begin
                alu_op   = hkrt_pkg::ALU_ADD;
                alu_a    = item_reg.now_ms;
                alu_b    = item_reg.hold_ms;
                ok_next  = 1'b0;
                rel_next = 1'b0;
                case (item_reg.func)
                    hkrt_pkg::FUNC_PRESS:
                    begin
                        if (!code_zero && hit_reg)
                        begin
                            // merge into the slot that already holds the code
                            wr_word.consumes = hit_word_reg.consumes | item_reg.consumes_flag;
                            cmd.wr_word      = 1'b1;
                            ok_next          = 1'b1;
                        end
                        else if (!code_zero && free_vld_reg)
                        begin
                            wr_idx           = free_idx_reg;
                            wr_word.key      = item_reg.key_code;
                            wr_word.deadline = alu_sum;
                            wr_word.consumes = item_reg.consumes_flag;
                            cmd.wr_word      = 1'b1;
                            cmd.set_used     = 1'b1;
                            cmd.clr_asked    = 1'b1;
                            ok_next          = 1'b1;
                        end
                    end
                    hkrt_pkg::FUNC_REQUEST:
                    begin
                        if (!code_zero && hit_reg)
                        begin
                            cmd.set_asked = 1'b1;
                            ok_next       = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            cmd.clr_used  = 1'b1;
                            cmd.clr_asked = 1'b1;
                            ok_next       = 1'b1;
                            rel_next      = 1'b1;
                        end
                    end
                endcase
                state_next = hkrt_pkg::ST_DONE;
            end
            hkrt_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_taken)
                begin
                    state_next = hkrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hkrt_pkg::ST_IDLE;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
            ok_reg       <= 1'b0;
            rel_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            free_vld_reg <= free_vld_next;
            ok_reg       <= ok_next;
            rel_reg      <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_word_reg <= hit_word_next;
        free_idx_reg <= free_idx_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hkrt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkrt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire hkrt_pkg::out_item_t out_item
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // a reported code always comes from a successful pop
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.released_code != 16'd0) |-> out_item.ok)
        else $error("released code without ok");

    // no consumes mark without a released code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.released_code == 16'd0) |-> !out_item.released_consumes)
        else $error("consumes mark without released code");

    // a waiting release needs a used slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.release_waiting |-> !out_item.table_empty)
        else $error("release waiting in an empty table");

endmodule

bind held_key_release_table_unit hkrt_checker u_hkrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
